/* hw/rtl/afte_pkg.sv */
// shared types and constants for the api frame transmit encoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package afte_pkg;

	localparam logic [7:0] START_DELIM = 8'h7E;
	localparam logic [7:0] ESC_CHAR    = 8'h7D;
	localparam logic [7:0] XON_CHAR    = 8'h11;
	localparam logic [7:0] XOFF_CHAR   = 8'h13;
	localparam logic [7:0] ESC_XOR     = 8'h20;
	localparam logic [7:0] LEN_HIGH    = 8'h00;
	localparam logic [7:0] CSUM_BASE   = 8'hFF;

	// one input transfer
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] frame_length;
		logic       last_byte;
	} in_item_t;

	// one output transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       first;
		logic       last;
		logic [7:0] length;
		logic [7:0] data;
		logic [7:0] csum;
		logic       esc_len;
		logic       esc_data;
		logic       esc_csum;
	} entry_t;

	function automatic logic is_special(input logic [7:0] b);
		return (b == START_DELIM) || (b == ESC_CHAR) || (b == XON_CHAR) || (b == XOFF_CHAR);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/afte_front.sv */
// front end: accepts data bytes, tracks frame state and checksum, classifies escapes
// depends on afte_pkg
`timescale 1ns / 1ps
`default_nettype none

module afte_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic              in_valid,
	input  wire afte_pkg::in_item_t in_data,
	input  wire logic              q_full,
	output logic                   in_stall,
	output logic                   push,
	output afte_pkg::entry_t       push_entry
);

	logic       escape_enable_q;
	logic       in_frame_q;
	logic [7:0] sum_q;
	logic [7:0] sum_new;
	logic [7:0] csum;
	logic       first;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign first    = !in_frame_q;
	assign sum_new  = (first ? 8'h00 : sum_q) + in_data.data_byte;
	assign csum     = afte_pkg::CSUM_BASE - sum_new;

	always_comb begin
		push_entry.first    = first;
		push_entry.last     = in_data.last_byte;
		push_entry.length   = in_data.frame_length;
		push_entry.data     = in_data.data_byte;
		push_entry.csum     = csum;
		push_entry.esc_len  = escape_enable_q && afte_pkg::is_special(in_data.frame_length);
		push_entry.esc_data = escape_enable_q && afte_pkg::is_special(in_data.data_byte);
		push_entry.esc_csum = escape_enable_q && afte_pkg::is_special(csum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b1;
			in_frame_q      <= 1'b0;
			sum_q           <= 8'h00;
		end else begin
			if (cfg_we) begin
				escape_enable_q <= cfg_wdata;
			end
			if (push) begin
				in_frame_q <= !in_data.last_byte;
				sum_q      <= in_data.last_byte ? 8'h00 : sum_new;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/afte_fifo.sv */
// small queue of classified entries between front and back
// depends on afte_pkg
`timescale 1ns / 1ps
`default_nettype none

module afte_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire afte_pkg::entry_t push_entry,
	input  wire logic             pop,
	output logic                  full,
	output logic                  head_valid,
	output afte_pkg::entry_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	afte_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/afte_back.sv */
// back end: walks one entry byte by byte, inserting escapes, into the output register
// depends on afte_pkg
`timescale 1ns / 1ps
`default_nettype none

module afte_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire afte_pkg::entry_t head,
	input  wire logic             out_stall,
	output logic                  pop,
	output logic                  out_valid,
	output afte_pkg::out_item_t   out_data
);

	typedef enum logic [2:0] {
		SLOT_DELIM,
		SLOT_LENHI,
		SLOT_LEN,
		SLOT_DATA,
		SLOT_CSUM
	} slot_t;

	slot_t               slot_q;
	slot_t               slot;
	slot_t               slot_next;
	slot_t               slot_end;
	logic                started_q;
	logic                esc_done_q;
	logic                out_valid_q;
	afte_pkg::out_item_t out_q;
	logic [7:0]          raw;
	logic                esc;
	logic                escape_now;
	logic                entry_done;
	logic                advance;
	afte_pkg::out_item_t item;

	assign slot     = started_q ? slot_q : (head.first ? SLOT_DELIM : SLOT_DATA);
	assign slot_end = head.last ? SLOT_CSUM : SLOT_DATA;

	always_comb begin
		unique case (slot)
			SLOT_DELIM: begin raw = afte_pkg::START_DELIM; esc = 1'b0;          slot_next = SLOT_LENHI; end
			SLOT_LENHI: begin raw = afte_pkg::LEN_HIGH;    esc = 1'b0;          slot_next = SLOT_LEN;   end
			SLOT_LEN:   begin raw = head.length;           esc = head.esc_len;  slot_next = SLOT_DATA;  end
			SLOT_DATA:  begin raw = head.data;             esc = head.esc_data; slot_next = SLOT_CSUM;  end
			SLOT_CSUM:  begin raw = head.csum;             esc = head.esc_csum; slot_next = SLOT_CSUM;  end
			default:    begin raw = head.data;             esc = 1'b0;          slot_next = SLOT_CSUM;  end
		endcase
	end

	assign escape_now = esc && !esc_done_q;
	assign entry_done = !escape_now && (slot == slot_end);
	assign advance    = head_valid && (!out_valid_q || !out_stall);
	assign pop        = advance && entry_done;

	always_comb begin
		item.out_byte  = escape_now ? afte_pkg::ESC_CHAR : (esc ? (raw ^ afte_pkg::ESC_XOR) : raw);
		item.frame_end = entry_done && (slot == SLOT_CSUM);
		item.run_last  = entry_done;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= SLOT_DELIM;
			started_q   <= 1'b0;
			esc_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (advance) begin
				out_q       <= item;
				out_valid_q <= 1'b1;
				if (escape_now) begin
					esc_done_q <= 1'b1;
					slot_q     <= slot;
					started_q  <= 1'b1;
				end else begin
					esc_done_q <= 1'b0;
					if (entry_done) begin
						started_q <= 1'b0;
					end else begin
						started_q <= 1'b1;
						slot_q    <= slot_next;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/api_frame_transmit_encoder_core.sv */
// api frame transmit encoder: byte-stuffed frame with 0x7e delimiter and checksum
// top level; instantiates afte_front, afte_fifo and afte_back, uses afte_pkg
//
// usage:
// - input channel (in_valid / in_stall / in_data) takes one frame-data byte per transfer;
//   frame_length is sampled on the first byte of a frame, last_byte closes the frame
// - output channel (out_valid / out_stall / out_data) gives one serial byte per transfer,
//   with frame_end on the final checksum byte and run_last on the last byte of each input
// - cfg_we / cfg_wdata write escape_enable (reset 1); write only while the block is idle
// - an input transfer produces 1 to 8 output bytes: header (delimiter, 0x00, length) on the
//   first byte of a frame, the data byte, and the checksum after the last byte; special
//   length, data and checksum bytes escaped as 0x7d plus byte xor 0x20 if escaping is on
// - an accepted input is registered in the queue, then its bytes in the output register
// - the back end emits one byte per cycle unless the output stalls or the queue is empty;
//   an item typically has 1 or 2 output bytes; the output byte rate sets the pace
// - the front classifies and queues items (QUEUE_DEPTH entries) so input keeps flowing
//   while the back end is busy or the receiver stalls
// - stall on the output holds the output register; once the queue fills, in_stall rises
// - reset clears frame state, the checksum, the queue and the output register
`timescale 1ns / 1ps
`default_nettype none

module api_frame_transmit_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire afte_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output afte_pkg::out_item_t      out_data
);

	// front to queue
	logic             push;
	afte_pkg::entry_t push_entry;
	logic             q_full;

	// queue to back
	logic             pop;
	logic             head_valid;
	afte_pkg::entry_t head;

	// classify items, keep running sum and frame state
	afte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.q_full     (q_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples the input pace from the output, one byte per cycle when not stalled
	afte_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// serialize header, data, checksum and escapes
	afte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

/* verif/api_frame_transmit_encoder_core_tb.sv */
// self-checking testbench for api_frame_transmit_encoder_core: directed frames, escape
// register writes, random frames under mixed sender idling and receiver stalls
// depends on afte_pkg and the core rtl; reads no files
`timescale 1ns / 1ps
`default_nettype none

module api_frame_transmit_encoder_core_tb;
	import afte_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_LIMIT = 20000;	// cycles allowed for outstanding bytes to drain
	localparam int TAIL_CYCLES = 8;		// quiet cycles after drain, catches stray bytes
	localparam int HOLD_CYCLES = 80;	// long receiver hold-off in the pressure test

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	api_frame_transmit_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// encoder model state, mirrors the block after reset
	bit         esc_on    = 1'b1;
	logic [7:0] csum_acc  = '0;
	bit         mid_frame = 1'b0;

	// serial bytes still owed by the block, oldest first
	out_item_t  line_bytes_due[$];

	// traffic shaping knobs: idle and stall percent per cycle, receiver hold-off length
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	// bookkeeping
	int failures      = 0;
	int bytes_checked = 0;
	int items_sent    = 0;
	int frames_sent   = 0;
	int escapes_due   = 0;
	int stall_cycles  = 0;

	// queue one line byte, stuffing it when escaping applies
	function automatic void push_line_byte(input logic [7:0] b, input bit may_escape);
		out_item_t r;
		if (may_escape && esc_on &&
		    (b == START_DELIM || b == ESC_CHAR || b == XON_CHAR || b == XOFF_CHAR)) begin
			r = '{out_byte: ESC_CHAR, frame_end: 1'b0, run_last: 1'b0};
			line_bytes_due.push_back(r);
			b = b ^ ESC_XOR;
			escapes_due++;
		end
		r = '{out_byte: b, frame_end: 1'b0, run_last: 1'b0};
		line_bytes_due.push_back(r);
	endfunction

	// work out every line byte one accepted data byte causes
	function automatic void encode_api_byte(input in_item_t it);
		out_item_t tail;
		// header opens the frame; the delimiter itself is never stuffed
		if (!mid_frame) begin
			push_line_byte(START_DELIM, 1'b0);
			push_line_byte(LEN_HIGH, 1'b1);
			push_line_byte(it.frame_length, 1'b1);
			csum_acc  = '0;
			mid_frame = 1'b1;
		end
		push_line_byte(it.data_byte, 1'b1);
		csum_acc = 8'(csum_acc + it.data_byte);
		// last flag closes the frame regardless of the advertised length
		if (it.last_byte) begin
			push_line_byte(8'(CSUM_BASE - csum_acc), 1'b1);
			tail = line_bytes_due.pop_back();
			tail.frame_end = 1'b1;
			line_bytes_due.push_back(tail);
			csum_acc  = '0;
			mid_frame = 1'b0;
			frames_sent++;
		end
		tail = line_bytes_due.pop_back();
		tail.run_last = 1'b1;
		line_bytes_due.push_back(tail);
	endfunction

	task automatic report_failure(input string what, input out_item_t want, input out_item_t got);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("[%0t] %s: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
			         $realtime, what, want.out_byte, want.frame_end, want.run_last,
			         got.out_byte, got.frame_end, got.run_last);
	endtask

	// one input transfer; sender gaps come first, valid stays up after acceptance
	task automatic send_data_byte(input logic [7:0] data, input logic [7:0] len, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= '{data_byte: data, frame_length: len, last_byte: last};
		@(posedge clk);
		while (in_stall) begin
			stall_cycles++;
			@(posedge clk);
		end
		encode_api_byte('{data_byte: data, frame_length: len, last_byte: last});
		items_sent++;
	endtask

	// sender goes quiet until every owed byte has come out
	task automatic wait_idle();
		int n;
		n = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (line_bytes_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (line_bytes_due.size() != 0) begin
			failures++;
			$display("[%0t] %0d line bytes never arrived", $realtime, line_bytes_due.size());
			line_bytes_due.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// escape register write, only with the block drained
	task automatic set_escape(input bit v);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		esc_on = v;
	endtask

	// random data byte, biased toward the stuffed values
	function automatic logic [7:0] pick_byte(input int special_pct);
		if ($urandom_range(99) < special_pct) begin
			case ($urandom_range(3))
				0: return START_DELIM;
				1: return ESC_CHAR;
				2: return XON_CHAR;
				default: return XOFF_CHAR;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// random frame; the length usually matches the byte count
	task automatic send_random_frame(input int nbytes, input int special_pct);
		logic [7:0] len;
		if ($urandom_range(9) == 0)
			len = 8'($urandom_range(255));
		else
			len = 8'(nbytes);
		for (int i = 0; i < nbytes; i++)
			send_data_byte(pick_byte(special_pct), len, i == nbytes - 1);
	endtask

	// receiver: long hold-off when requested, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// line byte checker: every output transfer against the oldest owed byte
	always @(posedge clk) begin : check_line_bytes
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			bytes_checked++;
			if (line_bytes_due.size() == 0) begin
				want = '0;
				report_failure("unexpected byte", want, out_data);
			end else begin
				want = line_bytes_due.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_failure("out_byte mismatch", want, out_data);
				else if (out_data.frame_end !== want.frame_end)
					report_failure("frame_end mismatch", want, out_data);
				else if (out_data.run_last !== want.run_last)
					report_failure("run_last mismatch", want, out_data);
			end
		end
	end

	// single-byte frames with header extremes, then a multi-byte frame; every stuffed value, escaping on
	task automatic test_header_extremes();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_data_byte(8'h00, 8'd1, 1'b1);
		send_data_byte(8'hFF, 8'hFF, 1'b1);
		// checksum comes out as 0x7e and gets stuffed, length too
		send_data_byte(8'h81, START_DELIM, 1'b1);
		// zero length goes out as given
		send_data_byte(START_DELIM, 8'h00, 1'b1);
		// multi-byte frame, data hitting each escaped value, length 0x7d
		send_data_byte(ESC_CHAR, ESC_CHAR, 1'b0);
		send_data_byte(XON_CHAR, XON_CHAR, 1'b0);
		send_data_byte(XOFF_CHAR, XOFF_CHAR, 1'b0);
		send_data_byte(8'hAA, 8'h55, 1'b1);
		wait_idle();
	endtask

	// advertised length disagrees with the byte count; last flag rules
	task automatic test_length_mismatch();
		send_data_byte(8'h10, 8'd5, 1'b0);
		send_data_byte(8'h20, 8'd5, 1'b1);
		for (int i = 0; i < 4; i++)
			send_data_byte(8'(8'h31 + i), 8'd1, i == 3);
		wait_idle();
	endtask

	// escaping off: stuffed values pass through raw, then back on
	task automatic test_unescaped();
		set_escape(1'b0);
		send_data_byte(START_DELIM, XOFF_CHAR, 1'b0);
		send_data_byte(ESC_CHAR, XOFF_CHAR, 1'b0);
		send_data_byte(XON_CHAR, XOFF_CHAR, 1'b0);
		send_data_byte(XOFF_CHAR, XOFF_CHAR, 1'b1);
		send_data_byte(8'h81, START_DELIM, 1'b1);
		set_escape(1'b1);
		send_data_byte(8'h81, START_DELIM, 1'b1);
		wait_idle();
	endtask

	// one random phase under the given idling mix and escape setting
	task automatic test_random_frames(input int n_items, input int idle_pct, input int stall_pct,
	                                  input bit esc);
		int nbytes;
		int start_items;
		set_escape(esc);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start_items    = items_sent;
		while (items_sent - start_items < n_items) begin
			// mostly short frames, now and then a long one
			if ($urandom_range(9) == 0)
				nbytes = $urandom_range(6, 24);
			else
				nbytes = $urandom_range(1, 5);
			send_random_frame(nbytes, 20);
		end
		wait_idle();
	endtask

	// receiver holds off for a long stretch while the sender keeps pushing
	task automatic test_receiver_hold();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = HOLD_CYCLES;
		for (int f = 0; f < 3; f++)
			send_random_frame(8, 30);
		// sender pauses until everything has come out
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_header_extremes();
		test_length_mismatch();
		test_unescaped();
		test_receiver_hold();
		test_random_frames(80, 0, 0, 1'b1);
		test_random_frames(80, 77, 0, 1'b0);
		test_random_frames(80, 0, 77, 1'b1);
		test_random_frames(80, 6, 6, 1'($urandom_range(1)));
		test_receiver_hold();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_idle();

		$display("covered %0d frames from %0d data bytes, %0d line bytes checked, %0d stuffed",
		         frames_sent, items_sent, bytes_checked, escapes_due);
		$display("both escape settings, long receiver hold-off, input stalled %0d cycles",
		         stall_cycles);
		if (failures == 0) begin
			$display("** api_frame_transmit_encoder_core: PASSED **");
		end else begin
			$display("%0d failures", failures);
			$display("** api_frame_transmit_encoder_core: FAILED **");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("timeout with %0d line bytes outstanding", line_bytes_due.size());
		$display("** api_frame_transmit_encoder_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

/* api_frame_transmit_encoder_core.f */
hw/rtl/afte_pkg.sv
hw/rtl/afte_front.sv
hw/rtl/afte_fifo.sv
hw/rtl/afte_back.sv
hw/rtl/api_frame_transmit_encoder_core.sv
verif/api_frame_transmit_encoder_core_tb.sv
